// File: sv/vdx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdx_pkg
// Shared types and constants for the vertex deduplication index core.
// ----------------------------------------------------------------------------
package vdx_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CountW     = $clog2(TableDepth + 1);
  localparam int unsigned KeyW       = 256;
  localparam int unsigned IndexW     = 12;

  typedef logic [KeyW-1:0]   key_t;
  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_en;
    logic wr_en;
    logic res_load;
    logic res_hit;
    logic res_ovf;
    logic scan_inc;
    logic scan_rst;
  } ctrl_t;

  typedef struct packed {
    logic match;
    logic scan_done;
    logic full;
  } stat_t;

endpackage

// File: sv/vdx_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdx_datapath
// Key memory, scan pointer, unique counter, comparator and result register.
// ----------------------------------------------------------------------------
module vdx_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vdx_pkg::key_t   key_i,
  input  vdx_pkg::ctrl_t  ctrl_i,
  output vdx_pkg::stat_t  stat_o,
  output logic [15:0]     res_o
);
  import vdx_pkg::*;

  key_t   mem [TableDepth];
  key_t   key_q, rd_q;
  count_t cnt_q, cnt_d, scan_q, hit_q;
  logic   [15:0] res_q, res_d;

  assign cnt_d = ctrl_i.clear ? '0 : cnt_q;

  always_comb begin
    res_d = '0;
    if (ctrl_i.res_hit) res_d[IndexW-1:0] = hit_q[IndexW-1:0];
    else if (ctrl_i.res_ovf) res_d[13] = 1'b1;
    else begin
      res_d[IndexW-1:0] = cnt_q[IndexW-1:0];
      res_d[12] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) key_q <= key_i;
    if (ctrl_i.rd_en) rd_q <= mem[scan_q[AddrW-1:0]];
    if (ctrl_i.wr_en) mem[cnt_q[AddrW-1:0]] <= key_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      scan_q <= '0;
      hit_q  <= '0;
    end else begin
      if (ctrl_i.wr_en) cnt_q <= cnt_q + count_t'(1);
      else cnt_q <= cnt_d;
      if (ctrl_i.scan_rst) scan_q <= '0;
      else if (ctrl_i.scan_inc) begin
        hit_q  <= scan_q;
        scan_q <= scan_q + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) res_q <= res_d;
  end

  assign stat_o.match     = (rd_q == key_q);
  assign stat_o.scan_done = (scan_q >= cnt_q);
  assign stat_o.full      = (cnt_q == count_t'(TableDepth));
  assign res_o = res_q;

endmodule

// File: sv/vdx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdx_ctrl
// Sequencer: accept, scan stored keys one at a time, insert, hold result.
// ----------------------------------------------------------------------------
module vdx_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           first_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  vdx_pkg::stat_t stat_i,
  output vdx_pkg::ctrl_t ctrl_o
);
  import vdx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e st_q, st_d;
  logic   ov_q, ov_d;

  always_comb begin
    st_d = st_q;
    ov_d = ov_q;
    ctrl_o = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      S_IDLE, S_OUT: begin
        if (st_q == S_OUT && out_ready_i) ov_d = 1'b0;
        if (!ov_q || out_ready_i) begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            ctrl_o.load = 1'b1;
            ctrl_o.clear = first_i;
            ctrl_o.scan_rst = 1'b1;
            st_d = S_RD;
          end else if (st_q == S_OUT && out_ready_i) st_d = S_IDLE;
        end
      end
      S_RD: begin
        if (stat_i.scan_done) begin
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_ovf = stat_i.full;
          ctrl_o.wr_en = !stat_i.full;
          ov_d = 1'b1;
          st_d = S_OUT;
        end else begin
          ctrl_o.rd_en = 1'b1;
          ctrl_o.scan_inc = 1'b1;
          st_d = S_CMP;
        end
      end
      S_CMP: st_d = S_FIN;
      S_FIN: begin
        if (stat_i.match) begin
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_hit = 1'b1;
          ov_d = 1'b1;
          st_d = S_OUT;
        end else st_d = S_RD;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  ap_wr_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_en |-> !stat_i.full) else $error("write on full table");
  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  ap_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_RD) |-> !in_ready_o) else $error("accept while busy");
endmodule

// File: sv/vertex_dedup_exact_index_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_exact_index_core
// Exact-match vertex deduplication: returns index, new and overflow flags.
// Each stored key compared is stepped through read, wait and compare states
// (S_RD, S_CMP, S_FIN); a miss ends in S_RD with the insert and result load.
// A new vertex is accepted only while no result is held or as it is taken.
// Reset: async active low; unique count cleared, key memory left undefined.
// ----------------------------------------------------------------------------
module vertex_dedup_exact_index_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // pos_x,pos_y,pos_z,tex_u,tex_v,norm_x,norm_y,norm_z
  input  logic         s_axis_tuser,  // first_of_mesh
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata   // vertex_index[11:0],is_new,overflow,pad
);
  import vdx_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  vdx_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .first_i(s_axis_tuser), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  vdx_datapath u_dp (
    .clk_i, .rst_ni, .key_i(s_axis_tdata), .ctrl_i(ctrl), .stat_o(stat),
    .res_o(m_axis_tdata)
  );
endmodule
